### rtl/core/firmware_image_xor_decryptor_macros.svh
// Assertion macros for the firmware image XOR decryptor.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FIRMWARE_IMAGE_XOR_DECRYPTOR_MACROS_SVH
`define FIRMWARE_IMAGE_XOR_DECRYPTOR_MACROS_SVH

// Check a property on a given clock, disabled while the given reset is low.
`define FXD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk_i, disabled while rst_ni is low.
`define FXD_ASSERT(lbl, prop, msg) \
  `FXD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/fxd_pkg.sv
// Shared types and constants of the firmware image XOR decryptor.
// No dependencies; imported by every module of the block.
`default_nettype none

package fxd_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int KEY_SLOTS   = 32;
  localparam int KEY_IDX_W   = 5;
  localparam int HASH_LEN    = 16;
  localparam int HASH_HALF   = HASH_LEN / 2;
  localparam int ROUNDS      = 3;
  localparam int FOLD_STEPS  = ((KEY_BYTES + HASH_LEN - 1) / HASH_LEN) * HASH_LEN;
  localparam int ROUND_STEPS = ROUNDS * HASH_LEN;
  localparam int STEP_W      = 6;
  localparam int POS_W       = 20;
  localparam int IDX_W       = 19;
  localparam int SIZE_W      = 20;

  localparam logic [31:0] MAX_IMAGE = 32'(512 * 1024);
  localparam logic [7:0]  MIX_BYTE  = 8'hAA;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam int APB_AW = 6;
  localparam int APB_DW = 64;

  localparam logic [2:0] REG_KEY0    = 3'd0;
  localparam logic [2:0] REG_KEY1    = 3'd1;
  localparam logic [2:0] REG_KEY2    = 3'd2;
  localparam logic [2:0] REG_KEY3    = 3'd3;
  localparam logic [2:0] REG_MAGIC   = 3'd4;
  localparam logic [2:0] REG_VERSION = 3'd5;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MAGIC   = 3'd1,
    ST_VERSION = 3'd2,
    ST_SIZE    = 3'd3,
    ST_ROOM    = 3'd4,
    ST_KEY     = 3'd5,
    ST_NOHDR   = 3'd6
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  cipher_byte;
    logic [31:0] header_magic;
    logic [31:0] header_version;
    logic [31:0] plain_length;
    logic [31:0] cipher_length;
    logic [63:0] digest_low;
    logic [63:0] digest_high;
    logic [31:0] space_limit;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        plain_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [SIZE_W-1:0] image_size;
    logic              final_byte;
  } out_item_t;

  typedef struct packed {
    logic                 hdr_load;
    logic                 data_load;
    logic                 fold_step;
    logic                 fold_xor;
    logic [KEY_IDX_W-1:0] fold_idx;
    logic                 round_step;
    logic                 hdr_finish;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

### rtl/core/fxd_ifs.sv
// Valid/ready channel interfaces for input and result items.
// Depends on nothing; field widths follow the item definitions in fxd_pkg.
`default_nettype none

interface fxd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  cipher_byte;
  logic [31:0] header_magic;
  logic [31:0] header_version;
  logic [31:0] plain_length;
  logic [31:0] cipher_length;
  logic [63:0] digest_low;
  logic [63:0] digest_high;
  logic [31:0] space_limit;

  modport source (
    output valid, opcode, cipher_byte, header_magic, header_version, plain_length,
    output cipher_length, digest_low, digest_high, space_limit,
    input  ready
  );
  modport sink (
    input  valid, opcode, cipher_byte, header_magic, header_version, plain_length,
    input  cipher_length, digest_low, digest_high, space_limit,
    output ready
  );
endinterface

interface fxd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  plain_byte;
  logic [18:0] byte_index;
  logic [19:0] image_size;
  logic        final_byte;

  modport source (
    output valid, status, plain_byte, byte_index, image_size, final_byte,
    input  ready
  );
  modport sink (
    input  valid, status, plain_byte, byte_index, image_size, final_byte,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/fxd_regs.sv
// APB configuration registers: expanded key words, expected magic and version.
// Depends on fxd_pkg.
`default_nettype none

module fxd_regs import fxd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [7:0]        key_o [KEY_SLOTS],
  output logic      [31:0]       magic_o,
  output logic      [31:0]       version_o
);

  logic [63:0] key_word_q [4];
  logic [63:0] key_word_d [4];
  logic [31:0] magic_q, magic_d;
  logic [31:0] version_q, version_d;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    key_word_d = key_word_q;
    magic_d    = magic_q;
    version_d  = version_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_KEY0:    key_word_d[0] = pwdata;
        REG_KEY1:    key_word_d[1] = pwdata;
        REG_KEY2:    key_word_d[2] = pwdata;
        REG_KEY3:    key_word_d[3] = pwdata;
        REG_MAGIC:   magic_d       = pwdata[31:0];
        REG_VERSION: version_d     = pwdata[31:0];
        default:     magic_d       = magic_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY0:    prdata = key_word_q[0];
      REG_KEY1:    prdata = key_word_q[1];
      REG_KEY2:    prdata = key_word_q[2];
      REG_KEY3:    prdata = key_word_q[3];
      REG_MAGIC:   prdata = {32'd0, magic_q};
      REG_VERSION: prdata = {32'd0, version_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word_q <= '{default: '0};
      magic_q    <= '0;
      version_q  <= '0;
    end else begin
      key_word_q <= key_word_d;
      magic_q    <= magic_d;
      version_q  <= version_d;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      key_o[i] = key_word_q[i / 8][(i % 8) * 8 +: 8];
    end
  end

  assign magic_o   = magic_q;
  assign version_o = version_q;

endmodule

`default_nettype wire

### rtl/core/fxd_datapath.sv
// Datapath: header checks, byte-serial key hash shift register, payload XOR
// and the result register. Driven by fxd_ctrl commands; depends on fxd_pkg.
`default_nettype none

module fxd_datapath import fxd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ctrl_cmd_t   cmd_i,
  input  wire in_item_t    item_i,
  input  wire logic [7:0]  key_i [KEY_SLOTS],
  input  wire logic [31:0] magic_i,
  input  wire logic [31:0] version_i,
  output out_item_t        result_o
);

  function automatic logic [7:0] rol1(input logic [7:0] b);
    return {b[6:0], b[7]};
  endfunction

  function automatic logic [7:0] ror1(input logic [7:0] b);
    return {b[0], b[7:1]};
  endfunction

  localparam logic [KEY_IDX_W-1:0] KEY_LAST = KEY_IDX_W'(KEY_BYTES - 1);

  logic                 hv_q, hv_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [POS_W-1:0]     len_q, len_d;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_d;
  status_e              pre_q, pre_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [POS_W-1:0]     clen_q, clen_d;
  logic [127:0]         expect_q, expect_d;
  logic [7:0]           digest_q [HASH_LEN];
  logic [7:0]           digest_d [HASH_LEN];
  logic [7:0]           fold_mix [HASH_LEN];
  logic [7:0]           round_mix;
  logic [127:0]         digest_flat;
  out_item_t            out_q, out_d;
  status_e              pre_st;
  status_e              final_st;
  logic [KEY_IDX_W-1:0] key_sel;
  logic [7:0]           key_pick;
  logic [POS_W:0]       pos_next;
  logic                 is_last;

  assign key_sel  = cmd_i.fold_step ? cmd_i.fold_idx : kidx_q;
  assign key_pick = key_i[key_sel];
  assign pos_next = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign is_last  = pos_next >= {1'b0, len_q};

  always_comb begin
    priority if (item_i.header_magic != magic_i) begin
      pre_st = ST_MAGIC;
    end else if (item_i.header_version != version_i) begin
      pre_st = ST_VERSION;
    end else if (item_i.plain_length == '0 || item_i.plain_length > MAX_IMAGE ||
                 item_i.cipher_length == '0 || item_i.cipher_length > MAX_IMAGE) begin
      pre_st = ST_SIZE;
    end else if (item_i.plain_length > item_i.space_limit) begin
      pre_st = ST_ROOM;
    end else begin
      pre_st = ST_OK;
    end
  end

  // Hash walks past tap 0: fold into taps 0, 1 and the middle, then rotate down.
  always_comb begin
    fold_mix = digest_q;
    if (cmd_i.fold_xor) begin
      fold_mix[0]         = digest_q[0] ^ key_pick;
      fold_mix[1]         = digest_q[1] ^ ror1(key_pick);
      fold_mix[HASH_HALF] = digest_q[HASH_HALF] ^ key_pick ^ MIX_BYTE;
    end
    round_mix = rol1(digest_q[0] ^ digest_q[1]);
    digest_d  = digest_q;
    priority if (cmd_i.hdr_load) begin
      digest_d = '{default: '0};
    end else if (cmd_i.fold_step) begin
      for (int j = 0; j < HASH_LEN; j++) begin
        digest_d[j] = fold_mix[(j + 1) % HASH_LEN];
      end
    end else if (cmd_i.round_step) begin
      for (int j = 0; j < HASH_LEN - 1; j++) begin
        digest_d[j] = digest_q[j + 1];
      end
      digest_d[HASH_LEN-1] = round_mix;
    end else begin
      digest_d = digest_q;
    end
  end

  always_comb begin
    for (int i = 0; i < HASH_LEN; i++) begin
      digest_flat[i*8 +: 8] = digest_q[i];
    end
  end

  assign final_st = (pre_q == ST_OK && digest_flat != expect_q) ? ST_KEY : pre_q;

  always_comb begin
    hv_d     = hv_q;
    pos_d    = pos_q;
    len_d    = len_q;
    kidx_d   = kidx_q;
    pre_d    = pre_q;
    size_d   = size_q;
    clen_d   = clen_q;
    expect_d = expect_q;
    out_d    = out_q;
    priority if (cmd_i.hdr_load) begin
      pre_d    = pre_st;
      size_d   = item_i.plain_length[SIZE_W-1:0];
      clen_d   = item_i.cipher_length[POS_W-1:0];
      expect_d = {item_i.digest_high, item_i.digest_low};
    end else if (cmd_i.hdr_finish) begin
      out_d        = '0;
      out_d.status = final_st;
      if (final_st == ST_OK) begin
        hv_d             = 1'b1;
        pos_d            = '0;
        kidx_d           = '0;
        len_d            = clen_q;
        out_d.image_size = size_q;
      end else begin
        hv_d = 1'b0;
      end
    end else if (cmd_i.data_load) begin
      out_d = '0;
      if (!hv_q) begin
        out_d.status = ST_NOHDR;
      end else begin
        out_d.status     = ST_OK;
        out_d.plain_byte = item_i.cipher_byte ^ key_pick ^ pos_q[7:0] ^ pos_q[15:8];
        out_d.byte_index = pos_q[IDX_W-1:0];
        out_d.final_byte = is_last;
        if (is_last) begin
          hv_d = 1'b0;
        end
        pos_d  = pos_next[POS_W-1:0];
        kidx_d = (kidx_q == KEY_LAST) ? '0 : kidx_q + KEY_IDX_W'(1);
      end
    end else begin
      out_d = out_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= 1'b0;
      pos_q  <= '0;
      len_q  <= '0;
      kidx_q <= '0;
    end else begin
      hv_q   <= hv_d;
      pos_q  <= pos_d;
      len_q  <= len_d;
      kidx_q <= kidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q    <= pre_d;
    size_q   <= size_d;
    clen_q   <= clen_d;
    expect_q <= expect_d;
    digest_q <= digest_d;
    out_q    <= out_d;
  end

  assign result_o = out_q;

endmodule

`default_nettype wire

### rtl/core/fxd_ctrl.sv
// Controller: input and result handshakes, hash step sequencing, datapath commands.
// Depends on fxd_pkg and the assertion macro header.
`default_nettype none
`include "firmware_image_xor_decryptor_macros.svh"

module fxd_ctrl import fxd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_opcode_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FOLD   = 2'd1;
  localparam logic [1:0] S_ROUND  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [STEP_W-1:0] FOLD_LAST  = STEP_W'(FOLD_STEPS - 1);
  localparam logic [STEP_W-1:0] ROUND_LAST = STEP_W'(ROUND_STEPS - 1);
  localparam logic [STEP_W-1:0] KEY_STEPS  = STEP_W'(KEY_BYTES);

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_opcode_i == OP_DATA) begin
            cmd_o.data_load = 1'b1;
            out_valid_d     = 1'b1;
          end else begin
            cmd_o.hdr_load = 1'b1;
            step_d         = '0;
            state_d        = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        cmd_o.fold_step = 1'b1;
        cmd_o.fold_xor  = step_q < KEY_STEPS;
        cmd_o.fold_idx  = step_q[KEY_IDX_W-1:0];
        if (step_q == FOLD_LAST) begin
          step_d  = '0;
          state_d = S_ROUND;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_ROUND: begin
        cmd_o.round_step = 1'b1;
        if (step_q == ROUND_LAST) begin
          step_d  = '0;
          state_d = S_FINISH;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.hdr_finish = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FXD_ASSERT(a_hdr_starts_hash, (in_valid_i && in_ready_o && in_opcode_i == OP_HEADER) |=> (state_q == S_FOLD && step_q == '0), "header did not start hash")
  `FXD_ASSERT(a_data_one_cycle, (in_valid_i && in_ready_o && in_opcode_i == OP_DATA) |=> (state_q == S_IDLE && out_valid_o), "data item result missing")
  `FXD_ASSERT(a_fold_to_round, (state_q == S_FOLD && step_q == FOLD_LAST) |=> (state_q == S_ROUND && step_q == '0), "fold phase length wrong")
  `FXD_ASSERT(a_finish_loads, cmd_o.hdr_finish |=> (out_valid_o && state_q == S_IDLE), "header result missing")

endmodule

`default_nettype wire

### rtl/core/firmware_image_xor_decryptor.sv
// Top level of the firmware image XOR decryptor: APB registers, controller, datapath.
// Depends on fxd_pkg, fxd_ifs, fxd_regs, fxd_ctrl and fxd_datapath.
//
//   channel  dir  handshake      content
//   in_i     in   valid/ready    header item or one encrypted byte
//   out_o    out  valid/ready    status, plain byte, index, image size, last flag
//   apb      in   psel/penable   key words, expected magic and version
//
// Data item: result registered at accept; one item per cycle if out_o.ready is high.
// Header item: load, then the fold and round steps of the byte-serial key hash
// shift register, then finish; no new item until the header result is loaded.
// A result waiting in the output register blocks input only while out_o.ready is low.
// Reset clears control state and the APB registers only; no clearing pass.
`default_nettype none

module firmware_image_xor_decryptor import fxd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  fxd_in_if.sink                 in_i,
  fxd_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  in_item_t   item;
  out_item_t  result;
  ctrl_cmd_t  cmd;
  logic [7:0] key [KEY_SLOTS];
  logic [31:0] magic;
  logic [31:0] version;

  assign item.opcode         = in_i.opcode;
  assign item.cipher_byte    = in_i.cipher_byte;
  assign item.header_magic   = in_i.header_magic;
  assign item.header_version = in_i.header_version;
  assign item.plain_length   = in_i.plain_length;
  assign item.cipher_length  = in_i.cipher_length;
  assign item.digest_low     = in_i.digest_low;
  assign item.digest_high    = in_i.digest_high;
  assign item.space_limit    = in_i.space_limit;

  fxd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_o     (key),
    .magic_o   (magic),
    .version_o (version)
  );

  fxd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  fxd_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .item_i    (item),
    .key_i     (key),
    .magic_i   (magic),
    .version_i (version),
    .result_o  (result)
  );

  assign out_o.status     = result.status;
  assign out_o.plain_byte = result.plain_byte;
  assign out_o.byte_index = result.byte_index;
  assign out_o.image_size = result.image_size;
  assign out_o.final_byte = result.final_byte;

endmodule

`default_nettype wire
